/* rtl/fes_pkg.sv */
// Shared constants, types and control structs for the fire effect stencil unit.
`timescale 1ns / 1ps
`default_nettype none
package fes_pkg;

  localparam int FRAME_WIDTH  = 256;
  localparam int FRAME_HEIGHT = 64;
  localparam int FRAME_DEPTH  = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int ADDR_W       = $clog2(FRAME_DEPTH);

  localparam int ROW_W    = 6;
  localparam int COL_W    = 8;
  localparam int CHANCE_W = 4;
  localparam int HEAT_W   = 8;

  // heat math: sum of four bytes, scaled by 32, divided by 129
  localparam int ACC_W      = HEAT_W + 2;
  localparam int HEAT_SCALE = 32;
  localparam int SCALE_SH   = $clog2(HEAT_SCALE);
  localparam int NUM_W      = ACC_W + SCALE_SH;
  localparam int DIVISOR    = 129;
  // 254 / 2^15 sits just under 1/129, so the estimate is low by at most one
  localparam int RECIP      = 254;
  localparam int DIV_SHIFT  = 15;
  localparam int PROD_W     = NUM_W + 8;

  localparam int SAT_VALUE  = 255;
  localparam int GAIN       = 3;
  localparam int DISP_W     = HEAT_W + 2;
  localparam logic [CHANCE_W-1:0] CHANCE_ALL = '1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_RD_B,
    ST_RD_RB,
    ST_RD_TB,
    ST_ACC,
    ST_MUL,
    ST_DIV,
    ST_RD_WAIT,
    ST_FINISH
  } fes_state_t;

  typedef enum logic [2:0] {
    SEL_SELF,
    SEL_LEFT_BELOW,
    SEL_BELOW,
    SEL_RIGHT_BELOW,
    SEL_TWO_BELOW
  } fes_addr_sel_t;

  typedef struct packed {
    logic          latch;
    logic          clr_wr;
    logic          seed_wr;
    logic          heat_wr;
    logic          mem_rd;
    fes_addr_sel_t addr_sel;
    logic          acc_load;
    logic          acc_add;
    logic          mul_en;
    logic          heat_load;
    logic          res_load;
  } fes_cmd_t;

  typedef struct packed {
    logic is_seed;
    logic in_frame;
    logic updatable;
    logic seed_take;
    logic clr_last;
    logic out_free;
  } fes_status_t;

endpackage
`default_nettype wire

/* rtl/fes_if.sv */
// Valid/ready channel interfaces for input items and result items.
`timescale 1ns / 1ps
`default_nettype none
interface fes_in_if import fes_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                mode;
  logic [ROW_W-1:0]    row;
  logic [COL_W-1:0]    column;
  logic                mask_bit;
  logic [CHANCE_W-1:0] chance_bits;
  logic [HEAT_W-1:0]   seed_byte;

  modport source (output valid, mode, row, column, mask_bit, chance_bits, seed_byte,
                  input ready);
  modport sink (input valid, mode, row, column, mask_bit, chance_bits, seed_byte,
                output ready);
endinterface

interface fes_out_if import fes_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [HEAT_W-1:0] display_value;
  logic              pixel_written;

  modport source (output valid, display_value, pixel_written, input ready);
  modport sink (input valid, display_value, pixel_written, output ready);
endinterface
`default_nettype wire

/* rtl/fes_datapath.sv */
// Datapath: item registers, single-port heat memory, accumulator, divider, result register.
`timescale 1ns / 1ps
`default_nettype none
module fes_datapath import fes_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire fes_cmd_t            cmd,
  output fes_status_t              status,
  input  wire logic                item_mode,
  input  wire logic [ROW_W-1:0]    item_row,
  input  wire logic [COL_W-1:0]    item_column,
  input  wire logic                item_mask_bit,
  input  wire logic [CHANCE_W-1:0] item_chance_bits,
  input  wire logic [HEAT_W-1:0]   item_seed_byte,
  input  wire logic                out_ready,
  output logic                     out_valid,
  output logic [HEAT_W-1:0]        out_display_value,
  output logic                     out_pixel_written
);

  logic                mode_r;
  logic [ROW_W-1:0]    row_r;
  logic [COL_W-1:0]    col_r;
  logic                mask_r;
  logic [CHANCE_W-1:0] chance_r;
  logic [HEAT_W-1:0]   seed_r;

  logic [HEAT_W-1:0]   heat_mem [FRAME_DEPTH];
  logic [HEAT_W-1:0]   rdata_r;
  logic [ADDR_W-1:0]   clr_cnt_r;
  logic [ACC_W-1:0]    acc_r;
  logic [PROD_W-1:0]   prod_r;
  logic [HEAT_W-1:0]   heat_r;
  logic                out_valid_r;
  logic [HEAT_W-1:0]   out_disp_r;
  logic                out_wr_r;

  logic [ADDR_W-1:0]   row_sel;
  logic [ADDR_W-1:0]   col_sel;
  logic [ADDR_W-1:0]   mem_addr;
  logic                mem_we;
  logic [HEAT_W-1:0]   mem_wdata;
  logic [NUM_W-1:0]    num;
  logic [HEAT_W-1:0]   q_est;
  logic [NUM_W-1:0]    rem;
  logic [HEAT_W-1:0]   quot;
  logic [DISP_W-1:0]   gain_val;
  logic [HEAT_W-1:0]   disp_val;
  logic                in_frame;
  logic                bottom;

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      mode_r   <= item_mode;
      row_r    <= item_row;
      col_r    <= item_column;
      mask_r   <= item_mask_bit;
      chance_r <= item_chance_bits;
      seed_r   <= item_seed_byte;
    end
  end

  assign in_frame = (int'(row_r) < FRAME_HEIGHT) && (int'(col_r) < FRAME_WIDTH);
  assign bottom   = (int'(row_r) + 1 >= FRAME_HEIGHT);

  always_comb begin
    status.is_seed   = !mode_r;
    status.in_frame  = in_frame;
    status.updatable = in_frame && (int'(row_r) + 2 < FRAME_HEIGHT) && (col_r != '0) &&
                       (int'(col_r) + 1 < FRAME_WIDTH);
    status.seed_take = in_frame && mask_r && (chance_r == CHANCE_ALL);
    status.clr_last  = (clr_cnt_r == ADDR_W'(FRAME_DEPTH - 1));
    status.out_free  = !out_valid_r || out_ready;
  end

  // neighbor address select
  always_comb begin
    row_sel = ADDR_W'(row_r);
    col_sel = ADDR_W'(col_r);
    unique case (cmd.addr_sel)
      SEL_SELF: begin
      end
      SEL_LEFT_BELOW: begin
        row_sel = ADDR_W'(row_r) + ADDR_W'(1);
        col_sel = ADDR_W'(col_r) - ADDR_W'(1);
      end
      SEL_BELOW: begin
        row_sel = ADDR_W'(row_r) + ADDR_W'(1);
      end
      SEL_RIGHT_BELOW: begin
        row_sel = ADDR_W'(row_r) + ADDR_W'(1);
        col_sel = ADDR_W'(col_r) + ADDR_W'(1);
      end
      SEL_TWO_BELOW: begin
        row_sel = ADDR_W'(row_r) + ADDR_W'(2);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (cmd.clr_wr) begin
      mem_addr = clr_cnt_r;
    end else begin
      mem_addr = ADDR_W'(row_sel * ADDR_W'(FRAME_WIDTH)) + col_sel;
    end
    mem_we = cmd.clr_wr || cmd.seed_wr || cmd.heat_wr;
    priority if (cmd.clr_wr) begin
      mem_wdata = '0;
    end else if (cmd.seed_wr) begin
      mem_wdata = seed_r;
    end else begin
      mem_wdata = quot;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      heat_mem[mem_addr] <= mem_wdata;
    end else if (cmd.mem_rd) begin
      rdata_r <= heat_mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
    end
  end

  // sum, reciprocal multiply, one-step correction
  assign num   = {acc_r, SCALE_SH'(0)};
  assign q_est = HEAT_W'(prod_r >> DIV_SHIFT);
  assign rem   = num - NUM_W'(NUM_W'(q_est) * NUM_W'(DIVISOR));
  assign quot  = (rem >= NUM_W'(DIVISOR)) ? q_est + HEAT_W'(1) : q_est;

  always_ff @(posedge clk) begin
    if (cmd.acc_load) begin
      acc_r <= ACC_W'(rdata_r);
    end else if (cmd.acc_add) begin
      acc_r <= acc_r + ACC_W'(rdata_r);
    end
    if (cmd.mul_en) begin
      prod_r <= PROD_W'(num) * PROD_W'(RECIP);
    end
    if (cmd.heat_wr) begin
      heat_r <= quot;
    end else if (cmd.heat_load) begin
      heat_r <= rdata_r;
    end
  end

  assign gain_val = DISP_W'(heat_r) * DISP_W'(GAIN);
  assign disp_val = (gain_val > DISP_W'(SAT_VALUE)) ? HEAT_W'(SAT_VALUE) : HEAT_W'(gain_val);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      priority if (!in_frame) begin
        out_disp_r <= '0;
        out_wr_r   <= 1'b0;
      end else if (mask_r) begin
        out_disp_r <= HEAT_W'(SAT_VALUE);
        out_wr_r   <= 1'b1;
      end else if (bottom) begin
        out_disp_r <= '0;
        out_wr_r   <= 1'b0;
      end else begin
        out_disp_r <= disp_val;
        out_wr_r   <= 1'b1;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_display_value = out_disp_r;
  assign out_pixel_written = out_wr_r;

endmodule
`default_nettype wire

/* rtl/fes_ctrl.sv */
// Controller: sequences memory clear, seeding and the four-read stencil update.
`timescale 1ns / 1ps
`default_nettype none
module fes_ctrl import fes_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire fes_status_t status,
  output fes_cmd_t         cmd
);

  fes_state_t state_r;
  fes_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (status.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        priority if (status.is_seed) begin
          state_nxt = ST_IDLE;
        end else if (status.updatable) begin
          state_nxt = ST_RD_B;
        end else if (status.in_frame) begin
          state_nxt = ST_RD_WAIT;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_RD_B:    state_nxt = ST_RD_RB;
      ST_RD_RB:   state_nxt = ST_RD_TB;
      ST_RD_TB:   state_nxt = ST_ACC;
      ST_ACC:     state_nxt = ST_MUL;
      ST_MUL:     state_nxt = ST_DIV;
      ST_DIV:     state_nxt = ST_FINISH;
      ST_RD_WAIT: state_nxt = ST_FINISH;
      ST_FINISH: begin
        if (status.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.addr_sel = SEL_SELF;
    in_ready     = 1'b0;
    unique case (state_r)
      ST_CLEAR: cmd.clr_wr = 1'b1;
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
      end
      ST_DISPATCH: begin
        priority if (status.is_seed) begin
          cmd.seed_wr = status.seed_take;
        end else if (status.updatable) begin
          cmd.mem_rd   = 1'b1;
          cmd.addr_sel = SEL_LEFT_BELOW;
        end else if (status.in_frame) begin
          cmd.mem_rd = 1'b1;
        end else begin
        end
      end
      // each read's data is registered and used in the next state
      ST_RD_B: begin
        cmd.mem_rd   = 1'b1;
        cmd.addr_sel = SEL_BELOW;
        cmd.acc_load = 1'b1;
      end
      ST_RD_RB: begin
        cmd.mem_rd   = 1'b1;
        cmd.addr_sel = SEL_RIGHT_BELOW;
        cmd.acc_add  = 1'b1;
      end
      ST_RD_TB: begin
        cmd.mem_rd   = 1'b1;
        cmd.addr_sel = SEL_TWO_BELOW;
        cmd.acc_add  = 1'b1;
      end
      ST_ACC:     cmd.acc_add = 1'b1;
      ST_MUL:     cmd.mul_en = 1'b1;
      ST_DIV:     cmd.heat_wr = 1'b1;
      ST_RD_WAIT: cmd.heat_load = 1'b1;
      ST_FINISH:  cmd.res_load = status.out_free;
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

/* rtl/fire_effect_pixel_stencil_unit.sv */
// Top level of the fire effect pixel stencil unit.
// Seed item: accept, then an optional write of the seed byte; no result.
// Border compute item: own heat read, then result load; outside the frame, no read.
// Interior compute item: four reads on the single-port heat memory, one accumulate,
// reciprocal multiply, correct and write back, then result load; next item after that.
// Reset: a clearing pass writes zero to all 16384 heat entries, one a cycle;
// no item is accepted until it ends.
`timescale 1ns / 1ps
`default_nettype none
module fire_effect_pixel_stencil_unit import fes_pkg::*; (
  input wire logic  clk,
  input wire logic  rst_n,
  fes_in_if.sink    in_item,
  fes_out_if.source out_item
);

  fes_cmd_t    cmd;
  fes_status_t status;
  logic        ready;

  fes_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_item.valid),
    .in_ready (ready),
    .status   (status),
    .cmd      (cmd)
  );

  fes_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .item_mode         (in_item.mode),
    .item_row          (in_item.row),
    .item_column       (in_item.column),
    .item_mask_bit     (in_item.mask_bit),
    .item_chance_bits  (in_item.chance_bits),
    .item_seed_byte    (in_item.seed_byte),
    .out_ready         (out_item.ready),
    .out_valid         (out_item.valid),
    .out_display_value (out_item.display_value),
    .out_pixel_written (out_item.pixel_written)
  );

  assign in_item.ready = ready;

endmodule
`default_nettype wire

/* rtl/fes_checker.sv */
// Port-level checks for the stencil unit, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module fes_checker import fes_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [HEAT_W-1:0] out_display_value,
  input wire logic              out_pixel_written
);

  // clearing pass holds off input right after reset
  a_clear_blocks_input: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("input ready during reset or clearing pass");

  a_reset_no_result: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // one item in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while first still working");

  a_unwritten_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_pixel_written |-> out_display_value == '0)
    else $error("unwritten pixel carries a nonzero value");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_display_value) &&
                                $stable(out_pixel_written))
    else $error("stalled result changed");

endmodule

bind fire_effect_pixel_stencil_unit fes_checker u_fes_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_item.valid),
  .in_ready          (in_item.ready),
  .out_valid         (out_item.valid),
  .out_ready         (out_item.ready),
  .out_display_value (out_item.display_value),
  .out_pixel_written (out_item.pixel_written)
);
`default_nettype wire

/* bench/fire_effect_pixel_stencil_unit_test.sv */
// Self-checking testbench for the fire effect pixel stencil unit.
`timescale 1ns / 1ps
module fire_effect_pixel_stencil_unit_test;
  import fes_pkg::*;

  localparam logic MODE_SEED    = 1'b0;
  localparam logic MODE_COMPUTE = 1'b1;
  localparam int   COOL_SCALE   = 32;
  localparam int   COOL_DIVISOR = 129;
  localparam int   GREY_MAX     = 255;
  localparam int   GREY_GAIN    = 3;
  localparam int   RANDOM_ITEMS = 450;
  localparam int   DRAIN_CYCLES = 16;

  typedef struct packed {
    logic                mode;
    logic [ROW_W-1:0]    row;
    logic [COL_W-1:0]    column;
    logic                mask_bit;
    logic [CHANCE_W-1:0] chance_bits;
    logic [HEAT_W-1:0]   seed_byte;
  } stencil_item_t;

  typedef struct packed {
    logic [HEAT_W-1:0] display_value;
    logic              pixel_written;
  } pixel_result_t;

  logic clk = 1'b0;
  logic rst_n;

  fes_in_if  in_ch ();
  fes_out_if out_ch ();

  fire_effect_pixel_stencil_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_ch),
    .out_item (out_ch)
  );

  always #5 clk = ~clk;

  stencil_item_t pending_items[$];
  pixel_result_t expected_pixels[$];
  logic [HEAT_W-1:0] heat_map [FRAME_DEPTH];
  int total_queued;
  int accepted_count;
  int error_count;
  logic item_taken;
  stencil_item_t next_item;
  pixel_result_t got_pixel;
  pixel_result_t want_pixel;
  pixel_result_t new_pixel;

  task automatic report_mismatch(input string what);
    $display("mismatch @%0t: %s", $realtime, what);
    error_count++;
  endtask

  task automatic add_item(input logic mode, input int row, input int column, input logic mask,
                          input int chance, input int seed);
    stencil_item_t it;
    it.mode        = mode;
    it.row         = ROW_W'(row);
    it.column      = COL_W'(column);
    it.mask_bit    = mask;
    it.chance_bits = CHANCE_W'(chance);
    it.seed_byte   = HEAT_W'(seed);
    pending_items.push_back(it);
  endtask

  // Applies one item to the shadow heat map; returns 1 when a pixel result follows.
  function automatic bit predict_pixel(input stencil_item_t it, output pixel_result_t res);
    int r;
    int c;
    int idx;
    int sum;
    int grey;
    r   = int'(it.row);
    c   = int'(it.column);
    idx = r * FRAME_WIDTH + c;
    res = '0;
    if (it.mode == MODE_SEED) begin
      if (it.mask_bit && it.chance_bits == CHANCE_ALL)
        heat_map[idx] = it.seed_byte;
      return 0;
    end
    if (r + 2 < FRAME_HEIGHT && c >= 1 && c + 1 < FRAME_WIDTH) begin
      sum = int'(heat_map[idx + FRAME_WIDTH - 1]) + int'(heat_map[idx + FRAME_WIDTH]) +
            int'(heat_map[idx + FRAME_WIDTH + 1]) + int'(heat_map[idx + 2 * FRAME_WIDTH]);
      heat_map[idx] = HEAT_W'((sum * COOL_SCALE) / COOL_DIVISOR);
    end
    if (it.mask_bit) begin
      res.display_value = HEAT_W'(GREY_MAX);
      res.pixel_written = 1'b1;
    end else if (r + 1 < FRAME_HEIGHT) begin
      grey = int'(heat_map[idx]) * GREY_GAIN;
      res.display_value = HEAT_W'(grey > GREY_MAX ? GREY_MAX : grey);
      res.pixel_written = 1'b1;
    end
    return 1;
  endfunction

  // Idle phases by progress: sender light / receiver heavy, then swapped, then none.
  function automatic int idle_pct(input bit sender);
    int phase;
    phase = (total_queued == 0) ? 0 : (accepted_count * 3) / total_queued;
    case (phase)
      0: return sender ? 36 : 81;
      1: return sender ? 81 : 36;
      default: return 0;
    endcase
  endfunction

  // Driver: new item on the falling edge once the previous one was taken.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_ch.valid || item_taken) begin
        if (pending_items.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b1)) begin
          next_item = pending_items.pop_front();
          in_ch.valid       <= 1'b1;
          in_ch.mode        <= next_item.mode;
          in_ch.row         <= next_item.row;
          in_ch.column      <= next_item.column;
          in_ch.mask_bit    <= next_item.mask_bit;
          in_ch.chance_bits <= next_item.chance_bits;
          in_ch.seed_byte   <= next_item.seed_byte;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      out_ch.ready <= ($urandom_range(0, 99) >= idle_pct(1'b0));
    end
  end

  // Monitor: predict on each accepted item, check each accepted result.
  always @(posedge clk) begin
    if (!rst_n) begin
      item_taken <= 1'b0;
    end else begin
      item_taken <= in_ch.valid && in_ch.ready;
      if (out_ch.valid && out_ch.ready) begin
        got_pixel.display_value = out_ch.display_value;
        got_pixel.pixel_written = out_ch.pixel_written;
        if (expected_pixels.size() == 0) begin
          report_mismatch($sformatf("result with nothing pending: value %0d written %0b",
                                    got_pixel.display_value, got_pixel.pixel_written));
        end else begin
          want_pixel = expected_pixels.pop_front();
          if (got_pixel.display_value !== want_pixel.display_value)
            report_mismatch($sformatf("display_value got %0d expected %0d",
                                      got_pixel.display_value, want_pixel.display_value));
          if (got_pixel.pixel_written !== want_pixel.pixel_written)
            report_mismatch($sformatf("pixel_written got %0b expected %0b",
                                      got_pixel.pixel_written, want_pixel.pixel_written));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        accepted_count <= accepted_count + 1;
        if (predict_pixel({in_ch.mode, in_ch.row, in_ch.column, in_ch.mask_bit,
                           in_ch.chance_bits, in_ch.seed_byte}, new_pixel))
          expected_pixels.push_back(new_pixel);
      end
    end
  end

  initial begin
    int r;
    int c;
    int seed;
    logic mask;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.mode        = MODE_SEED;
    in_ch.row         = '0;
    in_ch.column      = '0;
    in_ch.mask_bit    = 1'b0;
    in_ch.chance_bits = '0;
    in_ch.seed_byte   = '0;
    out_ch.ready      = 1'b0;
    accepted_count    = 0;
    error_count       = 0;
    total_queued      = 0;
    foreach (heat_map[i]) heat_map[i] = '0;

    // directed: corners, bottom row, borders, seeds not taken, saturation
    add_item(MODE_COMPUTE, 0, 0, 1'b0, 0, 0);
    add_item(MODE_COMPUTE, 63, 0, 1'b0, 0, 0);
    add_item(MODE_COMPUTE, 63, 255, 1'b1, 0, 0);
    add_item(MODE_SEED, 63, 255, 1'b0, 15, 8'hAA);
    add_item(MODE_SEED, 63, 255, 1'b1, 14, 8'hAA);
    add_item(MODE_SEED, 63, 255, 1'b1, 15, 8'hAA);
    add_item(MODE_COMPUTE, 63, 255, 1'b0, 15, 8'hFF);
    add_item(MODE_SEED, 62, 128, 1'b1, 15, 8'hFF);
    add_item(MODE_COMPUTE, 62, 128, 1'b0, 0, 0);
    add_item(MODE_SEED, 0, 0, 1'b1, 15, 8'h55);
    add_item(MODE_COMPUTE, 0, 0, 1'b0, 0, 0);
    add_item(MODE_SEED, 0, 255, 1'b1, 15, 8'h01);
    add_item(MODE_COMPUTE, 0, 255, 1'b0, 0, 0);
    add_item(MODE_SEED, 11, 99, 1'b1, 15, 8'hFF);
    add_item(MODE_SEED, 11, 100, 1'b1, 15, 8'hFF);
    add_item(MODE_SEED, 11, 101, 1'b1, 15, 8'hFF);
    add_item(MODE_SEED, 12, 100, 1'b1, 15, 8'hFF);
    add_item(MODE_COMPUTE, 10, 100, 1'b0, 0, 0);
    add_item(MODE_COMPUTE, 9, 100, 1'b0, 0, 0);
    add_item(MODE_SEED, 11, 100, 1'b1, 15, 8'h00);
    add_item(MODE_COMPUTE, 10, 100, 1'b1, 0, 0);
    add_item(MODE_COMPUTE, 63, 128, 1'b1, 15, 8'hFF);
    add_item(MODE_SEED, 62, 1, 1'b1, 0, 8'h7F);

    // random: mostly seed-the-neighborhood-then-compute sequences, some noise
    while (pending_items.size() < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) < 7) begin
        r = ($urandom_range(0, 9) == 0) ? $urandom_range(62, 63) : $urandom_range(0, 61);
        case ($urandom_range(0, 7))
          0: c = 1;
          1: c = FRAME_WIDTH - 2;
          default: c = $urandom_range(1, FRAME_WIDTH - 2);
        endcase
        for (int k = 0; k < 4; k++) begin
          if ($urandom_range(0, 3) != 0) begin
            seed = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 255);
            mask = ($urandom_range(0, 7) != 0);
            if (k < 3 && r + 1 < FRAME_HEIGHT)
              add_item(MODE_SEED, r + 1, c - 1 + k, mask, mask ? 15 : $urandom_range(0, 15),
                       seed);
            else if (k == 3 && r + 2 < FRAME_HEIGHT)
              add_item(MODE_SEED, r + 2, c, mask, 15, seed);
          end
        end
        add_item(MODE_COMPUTE, r, c, ($urandom_range(0, 3) == 0), $urandom_range(0, 15),
                 $urandom_range(0, 255));
        // carry the heat one row further up now and then
        if (r > 0 && $urandom_range(0, 1) == 0) begin
          add_item(MODE_COMPUTE, r - 1, c, ($urandom_range(0, 5) == 0), $urandom_range(0, 15),
                   $urandom_range(0, 255));
        end
      end else begin
        add_item($urandom_range(0, 1), $urandom_range(0, 63), $urandom_range(0, 255),
                 $urandom_range(0, 1), $urandom_range(0, 15), $urandom_range(0, 255));
      end
    end
    total_queued = pending_items.size();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (accepted_count < total_queued || expected_pixels.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  // Covers the clearing pass after reset plus the slowest stall pattern, several times over.
  initial begin
    #3_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

/* filelist.f */
rtl/fes_pkg.sv
rtl/fes_if.sv
rtl/fes_datapath.sv
rtl/fes_ctrl.sv
rtl/fire_effect_pixel_stencil_unit.sv
rtl/fes_checker.sv
bench/fire_effect_pixel_stencil_unit_test.sv
